### src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### src/psm_pkg.sv
package psm_pkg;

   localparam int STACK_DEPTH = 1024;
   localparam int CODE_DEPTH  = 2048;
   localparam int WORD_W      = 32;

   localparam int SA_W  = $clog2(STACK_DEPTH);
   localparam int PC_W  = $clog2(CODE_DEPTH);
   localparam int AW    = WORD_W + 4;
   localparam int CNT_W = $clog2(WORD_W);

   localparam int TOP_RESET  = 3;
   localparam int BASE_RESET = 1;

   typedef logic [WORD_W-1:0]     word_type;
   typedef logic signed [AW-1:0]  addr_type;

   // opcodes
   localparam logic [3:0] OP_LIT   = 4'd0;
   localparam logic [3:0] OP_OPR   = 4'd1;
   localparam logic [3:0] OP_LOD   = 4'd2;
   localparam logic [3:0] OP_LODAR = 4'd3;
   localparam logic [3:0] OP_STO   = 4'd4;
   localparam logic [3:0] OP_STOAR = 4'd5;
   localparam logic [3:0] OP_CAL   = 4'd6;
   localparam logic [3:0] OP_INT   = 4'd7;
   localparam logic [3:0] OP_JMP   = 4'd8;
   localparam logic [3:0] OP_JPC   = 4'd9;

   // operators of opr
   localparam logic [4:0] OPR_RET  = 5'd0;
   localparam logic [4:0] OPR_NEG  = 5'd1;
   localparam logic [4:0] OPR_ADD  = 5'd2;
   localparam logic [4:0] OPR_SUB  = 5'd3;
   localparam logic [4:0] OPR_MUL  = 5'd4;
   localparam logic [4:0] OPR_DIV  = 5'd5;
   localparam logic [4:0] OPR_MOD  = 5'd6;
   localparam logic [4:0] OPR_ODD  = 5'd7;
   localparam logic [4:0] OPR_EQ   = 5'd8;
   localparam logic [4:0] OPR_NE   = 5'd9;
   localparam logic [4:0] OPR_LT   = 5'd10;
   localparam logic [4:0] OPR_GE   = 5'd11;
   localparam logic [4:0] OPR_GT   = 5'd12;
   localparam logic [4:0] OPR_LE   = 5'd13;
   localparam logic [4:0] OPR_LAND = 5'd14;
   localparam logic [4:0] OPR_LOR  = 5'd15;
   localparam logic [4:0] OPR_NOT  = 5'd16;
   localparam logic [4:0] OPR_BAND = 5'd17;
   localparam logic [4:0] OPR_BOR  = 5'd18;
   localparam logic [4:0] OPR_BXOR = 5'd19;
   localparam logic [4:0] OPR_DUP  = 5'd20;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_DIVZ  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [3:0]         opcode;
      logic [3:0]         level_diff;
      logic signed [31:0] operand;
   } req_type;

   typedef struct packed {
      logic [PC_W-1:0]          next_pc;
      logic                     halted;
      logic                     print_valid;
      logic signed [WORD_W-1:0] print_value;
      logic [1:0]               status;
   } rsp_type;

   typedef struct packed {
      logic     start;
      logic [4:0] op;
      word_type a;
      word_type b;
   } alu_req_type;

   typedef struct packed {
      logic     done;
      word_type result;
   } alu_rsp_type;

   function automatic logic in_stack(addr_type a);
      return (a >= addr_type'(0)) && (a < addr_type'(STACK_DEPTH));
   endfunction

   function automatic addr_type sx(word_type w);
      return addr_type'($signed(w));
   endfunction

endpackage

### src/psm_ram.sv
module psm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/psm_alu.sv
module psm_alu (
   input  logic                clock,
   input  logic                reset,
   input  psm_pkg::alu_req_type alu_req,
   output psm_pkg::alu_rsp_type alu_rsp
);
   import psm_pkg::*;

   logic busy_ff, busy_in, fin_ff, fin_in, done_ff, done_in;
   logic is_mod_ff, is_mod_in, neg_q_ff, neg_q_in, neg_r_ff, neg_r_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   word_type rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in, res_ff, res_in;
   word_type a, b, simple, ma, mb;
   logic na, nb;
   logic [WORD_W:0] rem_sh, diff;

   assign a  = alu_req.a;
   assign b  = alu_req.b;
   assign na = a[WORD_W-1];
   assign nb = b[WORD_W-1];
   assign ma = na ? word_type'('0 - a) : a;
   assign mb = nb ? word_type'('0 - b) : b;

   always_comb begin
      case (alu_req.op)
         OPR_NEG:  simple = '0 - a;
         OPR_ADD:  simple = a + b;
         OPR_SUB:  simple = a - b;
         OPR_MUL:  simple = a * b;
         OPR_ODD:  simple = a[0] ? (a[WORD_W-1] ? '1 : word_type'(1)) : '0;
         OPR_EQ:   simple = word_type'(a == b);
         OPR_NE:   simple = word_type'(a != b);
         OPR_LT:   simple = word_type'($signed(a) < $signed(b));
         OPR_GE:   simple = word_type'(!($signed(a) < $signed(b)));
         OPR_GT:   simple = word_type'($signed(b) < $signed(a));
         OPR_LE:   simple = word_type'(!($signed(b) < $signed(a)));
         OPR_LAND: simple = word_type'((a != '0) && (b != '0));
         OPR_LOR:  simple = word_type'((a != '0) || (b != '0));
         OPR_NOT:  simple = word_type'(a == '0);
         OPR_BAND: simple = a & b;
         OPR_BOR:  simple = a | b;
         default:  simple = a ^ b;
      endcase
   end

   // one quotient bit per cycle, restoring
   assign rem_sh = {rem_ff, quo_ff[WORD_W-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      busy_in   = busy_ff;
      fin_in    = 1'b0;
      done_in   = 1'b0;
      is_mod_in = is_mod_ff;
      neg_q_in  = neg_q_ff;
      neg_r_in  = neg_r_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      res_in    = res_ff;
      if (alu_req.start) begin
         if (alu_req.op == OPR_DIV || alu_req.op == OPR_MOD) begin
            busy_in   = 1'b1;
            cnt_in    = '0;
            rem_in    = '0;
            quo_in    = ma;
            dvs_in    = mb;
            is_mod_in = (alu_req.op == OPR_MOD);
            neg_q_in  = na ^ nb;
            neg_r_in  = na;
         end else begin
            res_in  = simple;
            done_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (!diff[WORD_W]) begin
            rem_in = diff[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         if (is_mod_ff) begin
            res_in = neg_r_ff ? word_type'('0 - rem_ff) : rem_ff;
         end else begin
            res_in = neg_q_ff ? word_type'('0 - quo_ff) : quo_ff;
         end
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      is_mod_ff <= is_mod_in;
      neg_q_ff  <= neg_q_in;
      neg_r_ff  <= neg_r_in;
      cnt_ff    <= cnt_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dvs_ff    <= dvs_in;
      res_ff    <= res_in;
   end

   assign alu_rsp.done   = done_ff;
   assign alu_rsp.result = res_ff;

endmodule

### src/pcode_stack_machine_core.sv
// P-code stack machine: executes one instruction word per request.
// Request channel (req_): opcode, level difference and operand of the
// instruction found at the last reported next_pc. Response channel (rsp_):
// next pc, halt flag, printed value of a store and a status code.
// Both channels move a word when valid is high and stall is low.
// Each instruction walks L static links, makes R stack reads (0..3) and
// W stack writes (0..3); every stack access goes through the single
// read port and single write port of the stack RAM. Operators go
// through the shared ALU; div and mod use its bit-serial divider.
// One instruction is in flight at a time; req_stall is high until the
// result sits in the response register. The next request is taken while
// that response still waits, so a stalled receiver costs at most one word.
// Reset: synchronous; after it the stack RAM is zeroed by a clearing pass
// over all 1024 words, with req_stall high. Then top = 3, base = 1, pc = 0.
// After a halt (pc 0 or a fault) each request just echoes pc.
`include "assert_macros.svh"

module pcode_stack_machine_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  psm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output psm_pkg::rsp_type rsp_data
);
   import psm_pkg::*;

   typedef enum logic [10:0] {
      S_CLEAR     = 11'b000_0000_0001,
      S_IDLE      = 11'b000_0000_0010,
      S_WALK      = 11'b000_0000_0100,
      S_WALK_WAIT = 11'b000_0000_1000,
      S_READ      = 11'b000_0001_0000,
      S_READ_WAIT = 11'b000_0010_0000,
      S_EXEC      = 11'b000_0100_0000,
      S_ALU_WAIT  = 11'b000_1000_0000,
      S_PLAN      = 11'b001_0000_0000,
      S_WRITE     = 11'b010_0000_0000,
      S_DONE      = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // architectural state
   logic [SA_W-1:0] top_ff, top_in, base_ff, base_in, clr_ff, clr_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic            stopped_ff, stopped_in;

   // current instruction and its work registers
   logic [3:0]      opc_ff, opc_in, lv_ff, lv_in, lvl_ff, lvl_in;
   word_type        opw_ff, opw_in, w_ff, w_in, res_ff, res_in;
   addr_type        ea_ff, ea_in;
   word_type        rd_ff [3];
   word_type        rd_in [3];
   logic [1:0]      slot_ff, slot_in;

   // planned writes and new state
   logic [SA_W-1:0] wa_ff [3];
   logic [SA_W-1:0] wa_in [3];
   word_type        wd_ff [3];
   word_type        wd_in [3];
   logic [1:0]      wn_ff, wn_in, wi_ff, wi_in;
   logic [SA_W-1:0] ntop_ff, ntop_in, nbase_ff, nbase_in;
   logic [PC_W-1:0] npc_ff, npc_in;
   logic            print_ff, print_in;
   word_type        pval_ff, pval_in;

   rsp_type         out_ff, out_in, rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // RAM and ALU hookup
   logic            ram_we;
   logic [SA_W-1:0] ram_wa, ram_ra;
   word_type        ram_wd, ram_rd;
   alu_req_type     alu_req;
   alu_rsp_type     alu_rsp;

   // decode
   logic [4:0]      o;
   logic            opr_known, is_opr, is_ret, is_unary, is_dup, is_bin, is_divop;
   logic            needs_walk;
   logic [1:0]      n_rd;
   addr_type        top_s, base_s, slot_addr;
   logic [PC_W-1:0] pc1;

   // plan
   addr_type        pa [3];
   word_type        pd [3];
   logic [1:0]      pn;
   addr_type        p_top, p_base;
   logic [PC_W-1:0] p_pc;
   logic            p_print, plan_ok;
   word_type        p_val;

   logic            fault_go;
   logic [1:0]      fault_code;

   psm_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   psm_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign o          = opw_ff[4:0];
   assign opr_known  = (opw_ff[WORD_W-1:5] == '0) && (opw_ff[4:0] <= OPR_DUP);
   assign is_opr     = (opc_ff == OP_OPR) && opr_known;
   assign is_ret     = is_opr && (o == OPR_RET);
   assign is_unary   = is_opr && (o == OPR_NEG || o == OPR_ODD || o == OPR_NOT);
   assign is_dup     = is_opr && (o == OPR_DUP);
   assign is_bin     = is_opr && !is_ret && !is_unary && !is_dup;
   assign is_divop   = is_bin && (o == OPR_DIV || o == OPR_MOD);
   assign needs_walk = (opc_ff == OP_LOD) || (opc_ff == OP_LODAR) || (opc_ff == OP_STO) ||
                       (opc_ff == OP_STOAR) || (opc_ff == OP_CAL);
   assign top_s      = addr_type'(top_ff);
   assign base_s     = addr_type'(base_ff);
   assign pc1        = pc_ff + PC_W'(1);

   // read count and address of each read slot
   always_comb begin
      n_rd      = 2'd0;
      slot_addr = top_s;
      case (opc_ff)
         OP_OPR: begin
            if (is_ret) begin
               n_rd = 2'd3;
               case (slot_ff)
                  2'd0:    slot_addr = base_s + addr_type'(2);
                  2'd1:    slot_addr = base_s + addr_type'(1);
                  default: slot_addr = base_s - addr_type'(1);
               endcase
            end else if (is_bin) begin
               n_rd = 2'd2;
               if (slot_ff == 2'd0) slot_addr = top_s - addr_type'(1);
            end else if (is_unary || is_dup) begin
               n_rd = 2'd1;
            end
         end
         OP_LOD: begin
            n_rd      = 2'd1;
            slot_addr = ea_ff;
         end
         OP_LODAR: begin
            n_rd = 2'd2;
            if (slot_ff != 2'd0) slot_addr = ea_ff + sx(rd_ff[0]);
         end
         OP_STO: n_rd = 2'd1;
         OP_STOAR: begin
            n_rd = 2'd3;
            case (slot_ff)
               2'd0:    slot_addr = top_s - addr_type'(2);
               2'd1:    slot_addr = ea_ff + sx(rd_ff[0]);
               default: slot_addr = top_s;
            endcase
         end
         OP_JPC: n_rd = 2'd1;
         default: n_rd = 2'd0;
      endcase
   end

   // stack writes and new top, base, pc of the instruction
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pa[i] = '0;
         pd[i] = '0;
      end
      pn      = 2'd0;
      p_top   = top_s;
      p_base  = base_s;
      p_pc    = pc1;
      p_print = 1'b0;
      p_val   = '0;
      case (opc_ff)
         OP_LIT: begin
            p_top = top_s + addr_type'(1);
            pn    = 2'd1;
            pa[0] = p_top;
            pd[0] = opw_ff;
         end
         OP_OPR: begin
            if (is_ret) begin
               p_top  = base_s - addr_type'(1) - addr_type'(lv_ff);
               pn     = 2'd1;
               pa[0]  = p_top;
               pd[0]  = rd_ff[2];
               p_base = sx(rd_ff[1]);
               p_pc   = rd_ff[0][PC_W-1:0];
            end else if (is_unary) begin
               pn    = 2'd1;
               pa[0] = top_s;
               pd[0] = res_ff;
            end else if (is_dup) begin
               p_top = top_s + addr_type'(1);
               pn    = 2'd1;
               pa[0] = p_top;
               pd[0] = rd_ff[0];
            end else if (is_bin) begin
               p_top = top_s - addr_type'(1);
               pn    = 2'd1;
               pa[0] = p_top;
               pd[0] = res_ff;
            end
         end
         OP_LOD: begin
            p_top = top_s + addr_type'(1);
            pn    = 2'd1;
            pa[0] = p_top;
            pd[0] = rd_ff[0];
         end
         OP_LODAR: begin
            pn    = 2'd1;
            pa[0] = top_s;
            pd[0] = rd_ff[1];
         end
         OP_STO: begin
            pn      = 2'd1;
            pa[0]   = ea_ff;
            pd[0]   = rd_ff[0];
            p_print = 1'b1;
            p_val   = rd_ff[0];
            p_top   = top_s - addr_type'(1);
         end
         OP_STOAR: begin
            pn      = 2'd2;
            pa[0]   = ea_ff + sx(rd_ff[0]);
            pd[0]   = rd_ff[2];
            pa[1]   = top_s - addr_type'(2);
            pd[1]   = rd_ff[2];
            p_print = 1'b1;
            p_val   = rd_ff[2];
            p_top   = top_s - addr_type'(2);
         end
         OP_CAL: begin
            pn     = 2'd3;
            pa[0]  = top_s + addr_type'(2);
            pd[0]  = w_ff;
            pa[1]  = top_s + addr_type'(3);
            pd[1]  = word_type'(base_ff);
            pa[2]  = top_s + addr_type'(4);
            pd[2]  = word_type'(pc1);
            p_base = top_s + addr_type'(2);
            p_pc   = opw_ff[PC_W-1:0];
         end
         OP_INT: p_top = top_s + sx(opw_ff);
         OP_JMP: p_pc = opw_ff[PC_W-1:0];
         OP_JPC: begin
            if (rd_ff[0] == '0) p_pc = opw_ff[PC_W-1:0];
            p_top = top_s - addr_type'(1);
         end
         default: p_top = top_s;
      endcase
      plan_ok = in_stack(p_top) && in_stack(p_base) &&
                ((pn < 2'd1) || in_stack(pa[0])) &&
                ((pn < 2'd2) || in_stack(pa[1])) &&
                ((pn < 2'd3) || in_stack(pa[2]));
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      top_in       = top_ff;
      base_in      = base_ff;
      clr_in       = clr_ff;
      pc_in        = pc_ff;
      stopped_in   = stopped_ff;
      opc_in       = opc_ff;
      lv_in        = lv_ff;
      lvl_in       = lvl_ff;
      opw_in       = opw_ff;
      w_in         = w_ff;
      res_in       = res_ff;
      ea_in        = ea_ff;
      rd_in        = rd_ff;
      slot_in      = slot_ff;
      wa_in        = wa_ff;
      wd_in        = wd_ff;
      wn_in        = wn_ff;
      wi_in        = wi_ff;
      ntop_in      = ntop_ff;
      nbase_in     = nbase_ff;
      npc_in       = npc_ff;
      print_in     = print_ff;
      pval_in      = pval_ff;
      out_in       = out_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      fault_go     = 1'b0;
      fault_code   = ST_RANGE;
      ram_we       = 1'b0;
      ram_wa       = wa_ff[wi_ff];
      ram_wd       = wd_ff[wi_ff];
      ram_ra       = w_ff[SA_W-1:0];
      alu_req      = '0;
      alu_req.op   = o;
      alu_req.a    = rd_ff[0];
      alu_req.b    = rd_ff[1];

      // drop the response once taken
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            ram_wa = clr_ff;
            ram_wd = '0;
            clr_in = clr_ff + SA_W'(1);
            if (clr_ff == SA_W'(STACK_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               opc_in  = req_data.opcode;
               lv_in   = req_data.level_diff;
               lvl_in  = req_data.level_diff;
               opw_in  = word_type'(req_data.operand);
               w_in    = word_type'(base_ff);
               slot_in = 2'd0;
               wi_in   = 2'd0;
               if (stopped_ff) begin
                  out_in.next_pc     = pc_ff;
                  out_in.halted      = 1'b1;
                  out_in.print_valid = 1'b0;
                  out_in.print_value = '0;
                  out_in.status      = ST_OK;
                  state_in           = S_DONE;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            if (!needs_walk || lvl_ff == 4'd0) begin
               ea_in    = sx(w_ff) + sx(opw_ff);
               state_in = S_READ;
            end else if (!in_stack(sx(w_ff))) begin
               fault_go = 1'b1;
            end else begin
               ram_ra   = w_ff[SA_W-1:0];
               lvl_in   = lvl_ff - 4'd1;
               state_in = S_WALK_WAIT;
            end
         end
         S_WALK_WAIT: begin
            w_in     = ram_rd;
            state_in = S_WALK;
         end
         S_READ: begin
            if (slot_ff == n_rd) begin
               state_in = S_EXEC;
            end else if (!in_stack(slot_addr)) begin
               fault_go = 1'b1;
            end else begin
               ram_ra   = slot_addr[SA_W-1:0];
               state_in = S_READ_WAIT;
            end
         end
         S_READ_WAIT: begin
            rd_in[slot_ff] = ram_rd;
            slot_in        = slot_ff + 2'd1;
            state_in       = S_READ;
         end
         S_EXEC: begin
            if (is_divop && rd_ff[1] == '0) begin
               fault_go   = 1'b1;
               fault_code = ST_DIVZ;
            end else if (is_bin || is_unary) begin
               alu_req.start = 1'b1;
               state_in      = S_ALU_WAIT;
            end else begin
               state_in = S_PLAN;
            end
         end
         S_ALU_WAIT: begin
            if (alu_rsp.done) begin
               res_in   = alu_rsp.result;
               state_in = S_PLAN;
            end
         end
         S_PLAN: begin
            if (!plan_ok) begin
               fault_go = 1'b1;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  wa_in[i] = pa[i][SA_W-1:0];
                  wd_in[i] = pd[i];
               end
               wn_in    = pn;
               ntop_in  = p_top[SA_W-1:0];
               nbase_in = p_base[SA_W-1:0];
               npc_in   = p_pc;
               print_in = p_print;
               pval_in  = p_val;
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (wi_ff == wn_ff) begin
               // commit
               top_in             = ntop_ff;
               base_in            = nbase_ff;
               pc_in              = npc_ff;
               stopped_in         = (npc_ff == '0);
               out_in.next_pc     = npc_ff;
               out_in.halted      = (npc_ff == '0);
               out_in.print_valid = print_ff;
               out_in.print_value = print_ff ? pval_ff : '0;
               out_in.status      = ST_OK;
               state_in           = S_DONE;
            end else begin
               ram_we = 1'b1;
               wi_in  = wi_ff + 2'd1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = out_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // fault: advance pc, stop, nothing written
      if (fault_go) begin
         pc_in              = pc1;
         stopped_in         = 1'b1;
         out_in.next_pc     = pc1;
         out_in.halted      = 1'b1;
         out_in.print_valid = 1'b0;
         out_in.print_value = '0;
         out_in.status      = fault_code;
         state_in           = S_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         top_ff       <= SA_W'(TOP_RESET);
         base_ff      <= SA_W'(BASE_RESET);
         pc_ff        <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         top_ff       <= top_in;
         base_ff      <= base_in;
         pc_ff        <= pc_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      opc_ff   <= opc_in;
      lv_ff    <= lv_in;
      lvl_ff   <= lvl_in;
      opw_ff   <= opw_in;
      w_ff     <= w_in;
      res_ff   <= res_in;
      ea_ff    <= ea_in;
      rd_ff    <= rd_in;
      slot_ff  <= slot_in;
      wa_ff    <= wa_in;
      wd_ff    <= wd_in;
      wn_ff    <= wn_in;
      wi_ff    <= wi_in;
      ntop_ff  <= ntop_in;
      nbase_ff <= nbase_in;
      npc_ff   <= npc_in;
      print_ff <= print_in;
      pval_ff  <= pval_in;
      out_ff   <= out_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // stack is written only by the clearing pass or the commit sequence
   `ASSERT_SAME(a_we_state, clock, reset, ram_we, (state_ff == S_CLEAR) || (state_ff == S_WRITE))
   // a halted machine never writes the stack
   `ASSERT_SAME(a_stop_nowr, clock, reset, stopped_ff && (state_ff != S_CLEAR), !ram_we)
   // any fault status comes with halt
   `ASSERT_SAME(a_fault_halt, clock, reset, rsp_valid_ff && (rsp_ff.status != ST_OK), rsp_ff.halted)
   // an accepted request always leaves the idle state
   `ASSERT_NEXT(a_req_busy, clock, reset, req_valid && !req_stall, req_stall)

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import psm_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   pcode_stack_machine_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Machine state as the predictor sees it after every accepted word.
   word_type   stack_img [STACK_DEPTH];
   longint     mach_top;
   longint     mach_base;
   logic [10:0] mach_pc;
   bit         mach_halted;

   // Outcome of the last evaluated instruction, applied only on acceptance.
   longint     nx_top;
   longint     nx_base;
   logic [10:0] nx_pc;
   bit         nx_halted;
   int         flt;
   longint     wr_idx [3];
   word_type   wr_val [3];
   int         wr_cnt;

   rsp_type    predicted_rsp [$];
   int         errors = 0;
   int         cycles = 0;
   bit         quiet = 1'b0;
   int         hold_left = 0;

   function automatic longint as_int(word_type w);
      return longint'($signed(w));
   endfunction

   function automatic bit stack_ok(longint i);
      return i >= 0 && i < STACK_DEPTH;
   endfunction

   // Out-of-range reads flag a range fault and return zero.
   function automatic word_type rd_stack(longint i);
      if (!stack_ok(i)) begin
         if (flt == 0) flt = 2;
         return '0;
      end
      return stack_img[i];
   endfunction

   // Writes are held back until the instruction is known not to fault.
   function automatic void wr_stack(longint i, word_type v);
      if (!stack_ok(i)) begin
         if (flt == 0) flt = 2;
         return;
      end
      if (wr_cnt < 3) begin
         wr_idx[wr_cnt] = i;
         wr_val[wr_cnt] = v;
         wr_cnt++;
      end
   endfunction

   // Follow static links from the current frame base.
   function automatic word_type walk_links(int lv);
      word_type w;
      w = word_type'(mach_base);
      while (lv > 0 && flt == 0) begin
         w = rd_stack(as_int(w));
         lv--;
      end
      return w;
   endfunction

   // Division truncates toward zero, remainder follows the dividend.
   function automatic word_type div_or_mod(word_type a, word_type b, bit want_rem);
      word_type ma, mb, q, r;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      r = ma % mb;
      if (want_rem) return a[31] ? -r : r;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   function automatic word_type alu_op(logic [4:0] op, word_type x, word_type y);
      case (op)
         OPR_ADD:  return x + y;
         OPR_SUB:  return x - y;
         OPR_MUL:  return x * y;
         OPR_DIV:  return div_or_mod(x, y, 1'b0);
         OPR_MOD:  return div_or_mod(x, y, 1'b1);
         OPR_EQ:   return word_type'(x == y);
         OPR_NE:   return word_type'(x != y);
         OPR_LT:   return word_type'($signed(x) < $signed(y));
         OPR_GE:   return word_type'(!($signed(x) < $signed(y)));
         OPR_GT:   return word_type'($signed(y) < $signed(x));
         OPR_LE:   return word_type'(!($signed(y) < $signed(x)));
         OPR_LAND: return word_type'(x != 0 && y != 0);
         OPR_LOR:  return word_type'(x != 0 || y != 0);
         OPR_BAND: return x & y;
         OPR_BOR:  return x | y;
         default:  return x ^ y;
      endcase
   endfunction

   // Work out the response of one instruction without touching the state.
   function automatic void exec_instr(input req_type r, output rsp_type p);
      word_type   opw, x, y, ret_w, link, printed;
      logic [31:0] o;
      longint     top, b, addr;
      logic [10:0] pc;
      bit         prt;
      p = '0;
      wr_cnt = 0;
      flt = 0;
      nx_top = mach_top;
      nx_base = mach_base;
      nx_pc = mach_pc;
      nx_halted = mach_halted;
      if (mach_halted) begin
         p.next_pc = mach_pc;
         p.halted = 1'b1;
         return;
      end
      opw = r.operand;
      top = mach_top;
      b = mach_base;
      pc = mach_pc + 11'd1;
      prt = 1'b0;
      printed = '0;
      case (r.opcode)
         OP_LIT: begin
            top++;
            wr_stack(top, opw);
         end
         OP_OPR: begin
            o = opw;
            if (o == OPR_RET) begin
               ret_w = rd_stack(b + 2);
               link = rd_stack(b + 1);
               x = rd_stack(b - 1);
               top = b - 1 - longint'(r.level_diff);
               pc = ret_w[10:0];
               b = as_int(link);
               wr_stack(top, x);
            end else if (o == OPR_NEG || o == OPR_ODD || o == OPR_NOT) begin
               x = rd_stack(top);
               if (o == OPR_NEG) y = -x;
               else if (o == OPR_NOT) y = word_type'(x == 0);
               else y = x[0] ? (x[31] ? '1 : 32'd1) : '0;
               wr_stack(top, y);
            end else if (o == OPR_DUP) begin
               x = rd_stack(top);
               top++;
               wr_stack(top, x);
            end else if (o <= OPR_BXOR) begin
               x = rd_stack(top - 1);
               y = rd_stack(top);
               if (flt == 0 && (o == OPR_DIV || o == OPR_MOD) && y == 0) begin
                  flt = 1;
               end else begin
                  top--;
                  if (flt == 0) wr_stack(top, alu_op(o[4:0], x, y));
               end
            end
         end
         OP_LOD: begin
            addr = as_int(walk_links(r.level_diff)) + as_int(opw);
            x = rd_stack(addr);
            top++;
            wr_stack(top, x);
         end
         OP_LODAR: begin
            y = walk_links(r.level_diff);
            addr = as_int(y) + as_int(opw) + as_int(rd_stack(top));
            x = rd_stack(addr);
            wr_stack(top, x);
         end
         OP_STO: begin
            addr = as_int(walk_links(r.level_diff)) + as_int(opw);
            x = rd_stack(top);
            wr_stack(addr, x);
            prt = 1'b1;
            printed = x;
            top--;
         end
         OP_STOAR: begin
            y = walk_links(r.level_diff);
            addr = as_int(y) + as_int(opw) + as_int(rd_stack(top - 2));
            x = rd_stack(top);
            wr_stack(addr, x);
            wr_stack(top - 2, x);
            prt = 1'b1;
            printed = x;
            top -= 2;
         end
         OP_CAL: begin
            x = walk_links(r.level_diff);
            wr_stack(top + 2, x);
            wr_stack(top + 3, word_type'(b));
            wr_stack(top + 4, word_type'(pc));
            b = top + 2;
            pc = opw[10:0];
         end
         OP_INT: top += as_int(opw);
         OP_JMP: pc = opw[10:0];
         OP_JPC: begin
            x = rd_stack(top);
            if (x == 0) pc = opw[10:0];
            top--;
         end
         default: ;
      endcase
      if (flt == 0 && (!stack_ok(top) || !stack_ok(b))) flt = 2;
      if (flt != 0) begin
         // a fault drops all writes, steps pc and stops the machine
         wr_cnt = 0;
         nx_pc = mach_pc + 11'd1;
         nx_halted = 1'b1;
         p.next_pc = nx_pc;
         p.halted = 1'b1;
         p.status = (flt == 1) ? ST_DIVZ : ST_RANGE;
         return;
      end
      nx_top = top;
      nx_base = b;
      nx_pc = pc;
      nx_halted = (pc == 0);
      p.next_pc = pc;
      p.halted = nx_halted;
      if (prt) begin
         p.print_valid = 1'b1;
         p.print_value = printed;
      end
   endfunction

   function automatic void apply_instr();
      for (int i = 0; i < wr_cnt; i++) stack_img[wr_idx[i]] = wr_val[i];
      mach_top = nx_top;
      mach_base = nx_base;
      mach_pc = nx_pc;
      mach_halted = nx_halted;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
      errors++;
   endtask

   // Offer one word, hold it until taken, then predict its response.
   task automatic send_word(input req_type r);
      rsp_type p;
      while (!quiet && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      exec_instr(r, p);
      apply_instr();
      predicted_rsp.push_back(p);
   endtask

   function automatic req_type make_req(logic [3:0] op, int lv, logic [31:0] opd);
      req_type r;
      r.opcode = op;
      r.level_diff = lv[3:0];
      r.operand = opd;
      return r;
   endfunction

   function automatic bit would_halt(req_type r);
      rsp_type p;
      exec_instr(r, p);
      return p.halted;
   endfunction

   // Send only if the machine stays alive; a halt is permanent.
   task automatic issue_live(logic [3:0] op, int lv, logic [31:0] opd);
      req_type r;
      r = make_req(op, lv, opd);
      if (!would_halt(r)) send_word(r);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return $urandom_range(3);
         3: return 32'hffff_ffff - $urandom_range(3);
         default: return $urandom;
      endcase
   endfunction

   // Random instruction, biased toward forms that keep running.
   function automatic req_type random_instr();
      int k, lv;
      k = $urandom_range(99);
      lv = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1);
      if (k < 22) return make_req(OP_LIT, $urandom_range(15), pick_value());
      if (k < 50) begin
         case ($urandom_range(9))
            0: return make_req(OP_OPR, $urandom_range(15), OPR_RET);
            1: return make_req(OP_OPR, $urandom_range(15), $urandom);
            2: return make_req(OP_OPR, $urandom_range(15), $urandom_range(31, 21));
            default: return make_req(OP_OPR, $urandom_range(15), $urandom_range(20, 1));
         endcase
      end
      if (k < 58) return make_req(OP_LOD, lv, $urandom_range(12) - 4);
      if (k < 64) return make_req(OP_LODAR, lv, $urandom_range(8) - 2);
      if (k < 72) return make_req(OP_STO, lv, $urandom_range(12) - 4);
      if (k < 76) return make_req(OP_STOAR, lv, $urandom_range(8) - 2);
      if (k < 82) return make_req(OP_CAL, lv, $urandom_range(2047, 1));
      if (k < 88) return make_req(OP_INT, lv, $urandom_range(10) - (mach_top > 400 ? 40 : 4));
      if (k < 93) return make_req(OP_JMP, lv, ($urandom_range(3) == 0) ? $urandom
                                                : $urandom_range(2047, 1));
      return make_req(OP_JPC, lv, $urandom_range(2047, 1));
   endfunction

   // Draw until something keeps the machine alive; fall back on a jump.
   task automatic send_random_live();
      req_type r;
      int tries;
      tries = 0;
      r = random_instr();
      while (would_halt(r) && tries < 30) begin
         r = random_instr();
         tries++;
      end
      if (would_halt(r)) r = make_req(OP_JMP, $urandom_range(15), $urandom_range(2047, 1));
      send_word(r);
   endtask

   // Receiver: random stall, plus long hold-offs counted here.
   always @(posedge clock) begin
      if (hold_left > 0) hold_left--;
      rsp_stall <= (hold_left > 0) || (!quiet && $urandom_range(99) < 26);
   end

   // Compare every accepted response word against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_rsp.size() == 0) begin
            report("unexpected word, next_pc", rsp_data.next_pc, 0);
         end else begin
            want = predicted_rsp.pop_front();
            if (rsp_data.next_pc !== want.next_pc)
               report("next_pc", rsp_data.next_pc, want.next_pc);
            if (rsp_data.halted !== want.halted)
               report("halted", rsp_data.halted, want.halted);
            if (rsp_data.print_valid !== want.print_valid)
               report("print_valid", rsp_data.print_valid, want.print_valid);
            if (rsp_data.print_value !== want.print_value)
               report("print_value", rsp_data.print_value, want.print_value);
            if (rsp_data.status !== want.status)
               report("status", rsp_data.status, want.status);
         end
      end
   end

   // Watchdog: a hung handshake ends the run.
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("pcode_stack_machine_core: mismatch");
      $finish;
   end

   // Extremes of arithmetic: overflow, min / -1, signed mod and odd.
   task automatic test_arith_extremes();
      issue_live(OP_LIT, 0, 32'h7fff_ffff);
      issue_live(OP_LIT, 15, 32'h8000_0000);
      issue_live(OP_OPR, 0, OPR_ADD);
      issue_live(OP_LIT, 0, 32'hffff_ffff);
      issue_live(OP_OPR, 0, OPR_MUL);
      issue_live(OP_LIT, 0, 32'h8000_0000);
      issue_live(OP_LIT, 0, 32'hffff_ffff);
      issue_live(OP_OPR, 0, OPR_DIV);
      issue_live(OP_LIT, 0, -7);
      issue_live(OP_LIT, 0, 2);
      issue_live(OP_OPR, 0, OPR_MOD);
      issue_live(OP_LIT, 0, -3);
      issue_live(OP_OPR, 0, OPR_ODD);
      issue_live(OP_OPR, 0, OPR_DUP);
      issue_live(OP_OPR, 0, OPR_NOT);
      // unknown operator with every level bit set: only pc moves
      issue_live(OP_OPR, 15, 32'hffff_ffff);
   endtask

   // Frames, array access, call and return, branches.
   task automatic test_control_flow();
      issue_live(OP_INT, 0, 4);
      issue_live(OP_LIT, 0, 12345);
      issue_live(OP_STO, 0, 5);
      issue_live(OP_LOD, 0, 5);
      issue_live(OP_LIT, 0, 0);
      issue_live(OP_LODAR, 0, 6);
      issue_live(OP_LIT, 0, 1);
      issue_live(OP_LIT, 0, 0);
      issue_live(OP_LIT, 0, 99);
      issue_live(OP_STOAR, 0, 5);
      issue_live(OP_CAL, 0, 200);
      issue_live(OP_INT, 0, 6);
      issue_live(OP_LOD, 1, 2);
      issue_live(OP_STO, 1, 3);
      issue_live(OP_LIT, 0, 5);
      issue_live(OP_OPR, 1, OPR_RET);
      issue_live(OP_LIT, 0, 0);
      issue_live(OP_JPC, 0, 300);
      issue_live(OP_LIT, 0, 1);
      issue_live(OP_JPC, 0, 5);
      issue_live(OP_JMP, 0, 32'hffff_ffff);
      issue_live(OP_JMP, 0, 10);
   endtask

   // Receiver holds off while the sender keeps offering words.
   task automatic test_backpressure();
      hold_left = 400;
      for (int i = 0; i < 20; i++) send_random_live();
   endtask

   task automatic test_random_program(int count);
      quiet = 1'b1;
      for (int i = 0; i < count; i++) begin
         if (i == 300) quiet = 1'b0;
         send_random_live();
      end
   endtask

   // One terminal event per run, picked by the seed, then echoes.
   task automatic test_halt_and_echo();
      issue_live(OP_INT, 0, 50 - mach_top);
      case ($urandom_range(2))
         0: begin
            issue_live(OP_LIT, 0, 9);
            issue_live(OP_LIT, 0, 0);
            send_word(make_req(OP_OPR, 0, ($urandom_range(1) == 0) ? OPR_DIV : OPR_MOD));
         end
         1: send_word(make_req(OP_INT, 0, -100000));
         default: send_word(make_req(OP_JMP, 0, 32'h8000_0000));
      endcase
      for (int i = 0; i < 10; i++) send_word(random_instr());
   endtask

   initial begin
      int settle;
      for (int i = 0; i < STACK_DEPTH; i++) stack_img[i] = '0;
      mach_top = TOP_RESET;
      mach_base = BASE_RESET;
      mach_pc = '0;
      mach_halted = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_arith_extremes();
      test_control_flow();
      test_backpressure();
      test_random_program(1580);
      test_halt_and_echo();
      req_valid <= 1'b0;

      // drain, then allow the slowest instruction's worth of cycles
      while (predicted_rsp.size() != 0) @(posedge clock);
      settle = 0;
      while (settle < 200) begin
         @(posedge clock);
         settle++;
      end
      if (errors == 0) begin
         $display("pcode_stack_machine_core: match");
      end else begin
         $display("pcode_stack_machine_core: mismatch");
      end
      $finish;
   end

endmodule
